FILE: sv/wpcb_pkg.sv
// Package with the shared types and constants of the weighted palette colour blend.
package wpcb_pkg;

  localparam int SLOT_COUNT = 8;
  localparam int CHAN_COUNT = 4;
  localparam int CHAN_W     = 8;
  localparam int WEIGHT_W   = 16;
  localparam int Q_SHIFT    = 7;
  localparam int CFG_IDX_W  = 4;
  localparam int SUM_W      = WEIGHT_W - Q_SHIFT;

  localparam logic [SUM_W-1:0] COLOR_LIMIT = SUM_W'(255);
  localparam logic [SUM_W-1:0] ALPHA_LIMIT = SUM_W'(128);

  localparam int CHAN_ALPHA = 3;

  typedef struct packed {
    logic [31:0] slot_color_0;
    logic [31:0] slot_color_1;
    logic [31:0] slot_color_2;
    logic [31:0] slot_color_3;
    logic [31:0] slot_color_4;
    logic [31:0] slot_color_5;
    logic [31:0] slot_color_6;
    logic [31:0] slot_color_7;
    logic        last_in;
  } in_item_t;

  typedef struct packed {
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic [7:0] alpha_out;
    logic       last_out;
  } out_item_t;

  // Control travelling alongside the data between pipeline stages.
  typedef struct packed {
    logic valid;
    logic last;
  } stage_ctl_t;

  typedef logic [SLOT_COUNT-1:0][WEIGHT_W-1:0] weight_arr_t;
  typedef logic [CHAN_COUNT-1:0][SLOT_COUNT-1:0][WEIGHT_W-1:0] prod_arr_t;

endpackage

FILE: sv/wpcb_prod.sv
// Product stage: each channel byte of each slot times the slot weight, low 16 bits registered.
module wpcb_prod (
  input  logic                 clk,
  input  logic                 rst_n,
  input  wpcb_pkg::stage_ctl_t ctl_in,
  input  wpcb_pkg::in_item_t   item_in,
  input  wpcb_pkg::weight_arr_t weight,
  output wpcb_pkg::stage_ctl_t ctl_out,
  output wpcb_pkg::prod_arr_t  prod_out
);
  import wpcb_pkg::*;

  logic [SLOT_COUNT-1:0][31:0] slot;
  prod_arr_t  prod_nxt;
  prod_arr_t  prod_r;
  stage_ctl_t ctl_r;

  assign slot = {item_in.slot_color_7, item_in.slot_color_6, item_in.slot_color_5,
                 item_in.slot_color_4, item_in.slot_color_3, item_in.slot_color_2,
                 item_in.slot_color_1, item_in.slot_color_0};

  always_comb begin
    for (int c = 0; c < CHAN_COUNT; c++) begin
      for (int k = 0; k < SLOT_COUNT; k++) begin
        // Only the low 16 bits are kept, so the weight's bit pattern is used as it is.
        prod_nxt[c][k] = {{(WEIGHT_W-CHAN_W){1'b0}}, slot[k][c*CHAN_W +: CHAN_W]} * weight[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else begin
      ctl_r <= ctl_in;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
  end

  assign ctl_out  = ctl_r;
  assign prod_out = prod_r;

endmodule

FILE: sv/wpcb_reduce.sv
// Reduction stage: wrapping sum of the products, Q7 shift and clamp per channel.
module wpcb_reduce (
  input  logic                 clk,
  input  logic                 rst_n,
  input  wpcb_pkg::stage_ctl_t ctl_in,
  input  wpcb_pkg::prod_arr_t  prod_in,
  output logic                 strobe,
  output wpcb_pkg::out_item_t  item_out
);
  import wpcb_pkg::*;

  logic [CHAN_COUNT-1:0][CHAN_W-1:0] chan_nxt;
  out_item_t item_nxt;
  out_item_t item_r;
  logic      strobe_r;

  always_comb begin
    logic [WEIGHT_W-1:0] acc;
    logic [SUM_W-1:0]    shifted;
    logic [SUM_W-1:0]    limit;
    for (int c = 0; c < CHAN_COUNT; c++) begin
      acc = '0;
      for (int k = 0; k < SLOT_COUNT; k++) begin
        acc = acc + prod_in[c][k];
      end
      shifted = acc[WEIGHT_W-1:Q_SHIFT];
      limit   = (c == CHAN_ALPHA) ? ALPHA_LIMIT : COLOR_LIMIT;
      chan_nxt[c] = (shifted < limit) ? shifted[CHAN_W-1:0] : limit[CHAN_W-1:0];
    end
    item_nxt.red_out   = chan_nxt[0];
    item_nxt.green_out = chan_nxt[1];
    item_nxt.blue_out  = chan_nxt[2];
    item_nxt.alpha_out = chan_nxt[CHAN_ALPHA];
    item_nxt.last_out  = ctl_in.last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= ctl_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
  end

  assign strobe   = strobe_r;
  assign item_out = item_r;

endmodule

FILE: sv/weighted_palette_color_blend.sv
// Top level of the eight-way weighted RGBA palette colour blend.
// A colour entry is taken whenever start is high; busy is never raised, so one entry may be
// transferred every clock cycle. Each entry yields exactly one result, shown on out_item with
// out_strobe high for a single cycle, after the entry has passed the input register, the
// product register and the result register in turn. The receiver cannot stall, so it must
// take every result in the cycle it appears. The eight Q7 weights are written through the
// cfg port, which is always ready; writes to an index beyond the eighth weight are ignored.
// Weights should only change while no entry is in flight.
module weighted_palette_color_blend (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  start,
  output logic                                  busy,
  input  wpcb_pkg::in_item_t                    in_item,
  output logic                                  out_strobe,
  output wpcb_pkg::out_item_t                   out_item,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [wpcb_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [wpcb_pkg::WEIGHT_W-1:0]         cfg_data
);
  import wpcb_pkg::*;

  weight_arr_t weight_r;
  in_item_t    in_r;
  stage_ctl_t  in_ctl_r;
  stage_ctl_t  prod_ctl;
  prod_arr_t   prod;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      weight_r <= '0;
    end else if (cfg_valid && cfg_ready && (cfg_index < CFG_IDX_W'(SLOT_COUNT))) begin
      weight_r[cfg_index[$clog2(SLOT_COUNT)-1:0]] <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_ctl_r <= '0;
    end else begin
      in_ctl_r.valid <= start && !busy;
      in_ctl_r.last  <= in_item.last_in;
    end
  end

  always_ff @(posedge clk) begin
    in_r <= in_item;
  end

  wpcb_prod u_prod (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl_in   (in_ctl_r),
    .item_in  (in_r),
    .weight   (weight_r),
    .ctl_out  (prod_ctl),
    .prod_out (prod)
  );

  wpcb_reduce u_reduce (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl_in   (prod_ctl),
    .prod_in  (prod),
    .strobe   (out_strobe),
    .item_out (out_item)
  );

endmodule

FILE: sv/wpcb_checker.sv
// Port-level checker for the weighted palette colour blend, with its bind statement.
module wpcb_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           start,
  input logic                           busy,
  input wpcb_pkg::in_item_t             in_item,
  input logic                           out_strobe,
  input wpcb_pkg::out_item_t            out_item
);
  import wpcb_pkg::*;

  // Every accepted entry gives a result on out_strobe.
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##3 out_strobe)
    else $error("accepted entry produced no result");

  // No result appears without a matching earlier entry transfer.
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(start && !busy, 3))
    else $error("result without a matching entry");

  a_last_kept: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (out_item.last_out == $past(in_item.last_in, 3)))
    else $error("last flag not carried with its entry");

  a_alpha_clamp: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> ({1'b0, out_item.alpha_out} <= ALPHA_LIMIT))
    else $error("alpha above its limit");

endmodule

bind weighted_palette_color_blend wpcb_checker u_wpcb_checker (.*);

FILE: bench/weighted_palette_color_blend_tb.sv
// Self-checking testbench for the eight-way weighted RGBA palette colour blend.
`timescale 1ns / 100ps

module weighted_palette_color_blend_tb;
  import wpcb_pkg::*;

  localparam int BLEND_LATENCY = 3;
  localparam int STALL_LIMIT   = 1000;
  localparam int REPORT_LIMIT  = 10;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WEIGHT_0, REG_WEIGHT_1, REG_WEIGHT_2, REG_WEIGHT_3,
    REG_WEIGHT_4, REG_WEIGHT_5, REG_WEIGHT_6, REG_WEIGHT_7
  } weight_reg_t;

  localparam int FIRST_UNUSED_IDX = REG_WEIGHT_7 + 1;

  typedef enum int {WK_BLEND, WK_SIGNED, WK_ANY} weight_mix_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  in_item_t             in_item = '0;
  logic                 out_strobe;
  out_item_t            out_item;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [WEIGHT_W-1:0]  cfg_data = '0;

  logic [WEIGHT_W-1:0] blend_weight [SLOT_COUNT];
  out_item_t           blend_expect_q [$];
  out_item_t           blend_want;
  int                  fail_count = 0;
  int                  idle_pct = 0;
  int                  stall_cycles = 0;

  weighted_palette_color_blend dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_item    (in_item),
    .out_strobe (out_strobe),
    .out_item   (out_item),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic out_item_t blend_predict(in_item_t it);
    logic [31:0]         slot [SLOT_COUNT];
    logic [WEIGHT_W-1:0] acc;
    logic [WEIGHT_W-1:0] prod;
    logic [SUM_W-1:0]    level;
    logic [SUM_W-1:0]    limit;
    logic [7:0]          chan [CHAN_COUNT];
    out_item_t           res;
    slot = '{it.slot_color_0, it.slot_color_1, it.slot_color_2, it.slot_color_3,
             it.slot_color_4, it.slot_color_5, it.slot_color_6, it.slot_color_7};
    for (int ch = 0; ch < CHAN_COUNT; ch++) begin
      acc = '0;
      // Products and the running sum both wrap at sixteen bits.
      for (int k = 0; k < SLOT_COUNT; k++) begin
        prod = slot[k][8*ch +: 8] * blend_weight[k];
        acc  = acc + prod;
      end
      level    = SUM_W'(acc >> Q_SHIFT);
      limit    = (ch == CHAN_ALPHA) ? ALPHA_LIMIT : COLOR_LIMIT;
      chan[ch] = (level < limit) ? level[7:0] : limit[7:0];
    end
    res.red_out   = chan[0];
    res.green_out = chan[1];
    res.blue_out  = chan[2];
    res.alpha_out = chan[CHAN_ALPHA];
    res.last_out  = it.last_in;
    return res;
  endfunction

  function automatic logic [WEIGHT_W-1:0] pick_weight(weight_mix_t mix);
    int v;
    case (mix)
      WK_BLEND: begin
        return WEIGHT_W'($urandom_range(0, 40));
      end
      WK_SIGNED: begin
        v = $urandom_range(0, 1024);
        return WEIGHT_W'(v - 512);
      end
      default: begin
        return WEIGHT_W'($urandom);
      end
    endcase
  endfunction

  function automatic logic [31:0] pick_color();
    logic [31:0] c;
    c = $urandom;
    // Saturated bytes turn up often, as they do in real palettes.
    for (int b = 0; b < CHAN_COUNT; b++) begin
      case ($urandom_range(0, 7))
        0: c[8*b +: 8] = 8'h00;
        1: c[8*b +: 8] = 8'hFF;
        default: ;
      endcase
    end
    return c;
  endfunction

  function automatic in_item_t random_entry(logic last);
    return in_item_t'({pick_color(), pick_color(), pick_color(), pick_color(),
                       pick_color(), pick_color(), pick_color(), pick_color(), last});
  endfunction

  function automatic in_item_t uniform_entry(logic [31:0] c, logic last);
    return in_item_t'({{SLOT_COUNT{c}}, last});
  endfunction

  task automatic write_weight(input logic [CFG_IDX_W-1:0] idx,
                              input logic [WEIGHT_W-1:0] value);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = value;
    do @(posedge clk); while (!cfg_ready);
    if (idx < SLOT_COUNT) begin
      blend_weight[idx[$clog2(SLOT_COUNT)-1:0]] = value;
    end
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic program_weights(input weight_mix_t mix);
    for (int k = 0; k < SLOT_COUNT; k++) begin
      write_weight(CFG_IDX_W'(REG_WEIGHT_0 + k), pick_weight(mix));
    end
  endtask

  // Called and left just after a falling edge; idle cycles carry junk data with start low.
  task automatic send_color(input in_item_t it);
    while ($urandom_range(0, 99) < idle_pct) begin
      start   = 1'b0;
      in_item = random_entry(1'($urandom_range(0, 1)));
      @(negedge clk);
    end
    start   = 1'b1;
    in_item = it;
    do @(posedge clk); while (busy);
    blend_expect_q.push_back(blend_predict(it));
    @(negedge clk);
    start = 1'b0;
  endtask

  task automatic send_list(input int n);
    for (int i = 0; i < n; i++) begin
      send_color(random_entry((i == n - 1) || ($urandom_range(0, 19) == 0)));
    end
  endtask

  // Weights may only change once nothing is in flight.
  task automatic drain_results();
    start = 1'b0;
    while (blend_expect_q.size() != 0) @(negedge clk);
    repeat (BLEND_LATENCY + 2) @(negedge clk);
  endtask

  task automatic test_reset_weights();
    send_color(uniform_entry(32'hFFFF_FFFF, 1'b0));
    send_color(random_entry(1'b1));
  endtask

  task automatic test_weight_extremes();
    logic [WEIGHT_W-1:0] extreme [4];
    extreme = '{16'h7FFF, 16'h8000, 16'hFFFF, 16'h0080};
    foreach (extreme[e]) begin
      drain_results();
      for (int k = 0; k < SLOT_COUNT; k++) begin
        write_weight(CFG_IDX_W'(REG_WEIGHT_0 + k), extreme[e]);
      end
      send_color(uniform_entry(32'hFFFF_FFFF, 1'b0));
      send_color(uniform_entry(32'h0000_0000, 1'b0));
      send_color(uniform_entry(32'h80FF_7F01, 1'b1));
    end
  endtask

  task automatic test_ignored_index();
    drain_results();
    program_weights(WK_SIGNED);
    for (int idx = FIRST_UNUSED_IDX; idx < 2**CFG_IDX_W; idx++) begin
      write_weight(CFG_IDX_W'(idx), WEIGHT_W'($urandom));
    end
    send_list(2);
  endtask

  // A list whose length is not a multiple of four must lose no entry.
  task automatic test_uneven_list();
    drain_results();
    program_weights(WK_BLEND);
    send_list(5);
  endtask

  task automatic test_random_stream(input int pct, input int n_items);
    int sent;
    int len;
    idle_pct = pct;
    for (int s = 0; s < 4; s++) begin
      drain_results();
      program_weights(weight_mix_t'(s % 3));
      sent = 0;
      while (sent < n_items / 4) begin
        len = $urandom_range(1, 9);
        send_list(len);
        sent += len;
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_strobe) begin
      if (blend_expect_q.size() == 0) begin
        fail_count++;
        if (fail_count <= REPORT_LIMIT) begin
          $display("Result with no entry outstanding: %p", out_item);
        end
      end else begin
        blend_want = blend_expect_q.pop_front();
        if (out_item.red_out !== blend_want.red_out ||
            out_item.green_out !== blend_want.green_out ||
            out_item.blue_out !== blend_want.blue_out ||
            out_item.alpha_out !== blend_want.alpha_out ||
            out_item.last_out !== blend_want.last_out) begin
          fail_count++;
          if (fail_count <= REPORT_LIMIT) begin
            $display("Mismatch: expected r=%0h g=%0h b=%0h a=%0h last=%0b",
                     blend_want.red_out, blend_want.green_out, blend_want.blue_out,
                     blend_want.alpha_out, blend_want.last_out);
            $display("          got      r=%0h g=%0h b=%0h a=%0h last=%0b",
                     out_item.red_out, out_item.green_out, out_item.blue_out,
                     out_item.alpha_out, out_item.last_out);
          end
        end
      end
    end
  end

  // Counts cycles in which no transfer of any kind takes place.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_strobe || (cfg_valid && cfg_ready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    foreach (blend_weight[k]) blend_weight[k] = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    idle_pct = 36;
    test_reset_weights();
    test_weight_extremes();
    test_ignored_index();
    test_uneven_list();
    test_random_stream(36, 264);
    test_random_stream(51, 264);
    test_random_stream(0, 264);
    drain_results();
    if (fail_count == 0 && blend_expect_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
